>>> design/dos_pkg.sv
// ============================================================================
// dos_pkg: shared definitions for the digit overlay stamp
// Widths, register indexes, reset values, pipeline beat types, the 3x5 font
// and the helper functions used by the pipeline and the decimal converter.
// ============================================================================
package dos_pkg;

    localparam int COORD_W     = 11;
    localparam int COLOR_W     = 16;
    localparam int SCALE_W     = 5;
    localparam int VALUE_W     = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int BCD_DIGITS  = 8;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int GLYPH_W     = 15;
    localparam int COUNT_W     = 5;

    localparam int FRAME_WIDTH         = 2048;
    localparam int FRAME_HEIGHT        = 2048;
    localparam int DEFAULT_DIGIT_COUNT = 7;
    localparam int ROW_COUNT           = 5;

    localparam logic [1:0]         GAP_COL     = 2'd3;
    localparam logic [COLOR_W-1:0] WHITE_LEVEL = 16'h00ff;
    localparam logic [COLOR_W-1:0] BLACK_LEVEL = 16'h0000;

    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAY_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SHOWN_VALUE    = 3'd4;

    localparam logic               RESET_OVERLAY_ENABLE = 1'b1;
    localparam logic [COORD_W-1:0] RESET_ORIGIN_X       = 11'd10;
    localparam logic [COORD_W-1:0] RESET_ORIGIN_Y       = 11'd30;
    localparam logic [SCALE_W-1:0] RESET_SCALE          = 5'd4;

    typedef enum logic
    {
        CONV_IDLE,
        CONV_RUN
    } conv_state_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] num;
        logic [COORD_W-1:0] quo;
        logic [SCALE_W-1:0] rem;
    } div_lane_t;

    typedef struct packed
    {
        logic               active;
        div_lane_t          lane_x;
        div_lane_t          lane_y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pix_beat_t;

    // One restoring division step: brings in the next dividend bit, MSB first.
    function automatic div_lane_t div_step(div_lane_t lane, logic [SCALE_W-1:0] divisor);
        logic [SCALE_W:0] trial;
        div_lane_t        result;
        trial      = {lane.rem, lane.num[COORD_W-1]};
        result.num = {lane.num[COORD_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor})
        begin
            result.rem = SCALE_W'(trial - {1'b0, divisor});
            result.quo = {lane.quo[COORD_W-2:0], 1'b1};
        end
        else
        begin
            result.rem = trial[SCALE_W-1:0];
            result.quo = {lane.quo[COORD_W-2:0], 1'b0};
        end
        return result;
    endfunction

    // Adds three to every decimal digit of five or more before the next shift.
    function automatic logic [BCD_W-1:0] bcd_adjust(logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] result;
        result = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                result[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return result;
    endfunction

    // 3x5 font, row-major, top-left cell in the most significant bit.
    function automatic logic [GLYPH_W-1:0] glyph_bits(logic [3:0] digit);
        logic [GLYPH_W-1:0] bits;
        unique case (digit)
            4'd0:    bits = 15'o75557;
            4'd1:    bits = 15'o26227;
            4'd2:    bits = 15'o25127;
            4'd3:    bits = 15'o71717;
            4'd4:    bits = 15'o13571;
            4'd5:    bits = 15'o74616;
            4'd6:    bits = 15'o34652;
            4'd7:    bits = 15'o71122;
            4'd8:    bits = 15'o75757;
            4'd9:    bits = 15'o35311;
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

>>> design/dos_bcd_conv.sv
// ============================================================================
// dos_bcd_conv: binary to decimal converter for the displayed value
// Shift-and-add-three sequencer, one bit per cycle. The digits in use are
// updated together once the conversion of a new value completes.
// ============================================================================
module dos_bcd_conv #(
    parameter int DIGIT_COUNT = dos_pkg::DEFAULT_DIGIT_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [dos_pkg::VALUE_W-1:0]     value,
    output logic                            busy,
    output logic [DIGIT_COUNT-1:0][3:0]     digits
);

    dos_pkg::conv_state_t state_reg;
    dos_pkg::conv_state_t state_next;

    logic [dos_pkg::VALUE_W-1:0] shift_reg;
    logic [dos_pkg::BCD_W-1:0]   bcd_reg;
    logic [dos_pkg::COUNT_W-1:0] count_reg;
    logic [DIGIT_COUNT-1:0][3:0] digits_reg;

    logic [dos_pkg::BCD_W-1:0]   bcd_adj;
    logic [dos_pkg::BCD_W-1:0]   bcd_next;
    logic                        last_step;

    assign bcd_adj   = dos_pkg::bcd_adjust(bcd_reg);
    assign bcd_next  = {bcd_adj[dos_pkg::BCD_W-2:0], shift_reg[dos_pkg::VALUE_W-1]};
    assign last_step = (count_reg == dos_pkg::COUNT_W'(dos_pkg::VALUE_W - 1));

    always_comb
    begin
        state_next = state_reg;
        if (start)
        begin
            state_next = dos_pkg::CONV_RUN;
        end
        else
        begin
            unique case (state_reg)
                dos_pkg::CONV_IDLE: state_next = dos_pkg::CONV_IDLE;
                dos_pkg::CONV_RUN:  state_next = last_step ? dos_pkg::CONV_IDLE
                                                           : dos_pkg::CONV_RUN;
                default:            state_next = dos_pkg::CONV_IDLE;
            endcase
        end
    end

    always_comb
    begin
        unique case (state_reg)
            dos_pkg::CONV_IDLE: busy = 1'b0;
            dos_pkg::CONV_RUN:  busy = 1'b1;
            default:            busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dos_pkg::CONV_IDLE;
            count_reg  <= '0;
            digits_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                count_reg <= '0;
            end
            else if (state_reg == dos_pkg::CONV_RUN)
            begin
                count_reg <= count_reg + 1'b1;
                if (last_step)
                begin
                    digits_reg <= bcd_next[4*DIGIT_COUNT-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= value;
            bcd_reg   <= '0;
        end
        else if (state_reg == dos_pkg::CONV_RUN)
        begin
            shift_reg <= {shift_reg[dos_pkg::VALUE_W-2:0], 1'b0};
            bcd_reg   <= bcd_next;
        end
    end

    assign digits = digits_reg;

endmodule

>>> design/dos_div_stage.sv
// ============================================================================
// dos_div_stage: one register stage of the cell coordinate divider
// Runs a few restoring division steps on the column and row lanes of a beat
// and holds the result until the next stage takes it.
// ============================================================================
module dos_div_stage #(
    parameter int STEPS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dos_pkg::SCALE_W-1:0]   divisor,
    input  logic                          up_valid,
    input  dos_pkg::pix_beat_t            up_beat,
    output logic                          up_ready,
    output logic                          down_valid,
    output dos_pkg::pix_beat_t            down_beat,
    input  logic                          down_ready
);

    logic               valid_reg;
    dos_pkg::pix_beat_t beat_reg;
    dos_pkg::pix_beat_t beat_next;

    always_comb
    begin
        dos_pkg::div_lane_t lx;
        dos_pkg::div_lane_t ly;
        lx = up_beat.lane_x;
        ly = up_beat.lane_y;
        for (int i = 0; i < STEPS; i++)
        begin
            lx = dos_pkg::div_step(lx, divisor);
            ly = dos_pkg::div_step(ly, divisor);
        end
        beat_next        = up_beat;
        beat_next.lane_x = lx;
        beat_next.lane_y = ly;
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_beat  = beat_reg;

endmodule

>>> design/digit_overlay_stamp_core.sv
// ============================================================================
// digit_overlay_stamp_core: decimal number overlay for an RGB pixel stream
// Stamps the configured value as scaled 3x5 digits in a black box.
// ============================================================================
// Pixels enter on the in channel (in_valid, in_stall) with their column, row
// and color, and leave in the same order on the out channel (out_valid,
// out_stall), one output beat for each input beat. The pipeline has five
// register stages: origin offset and bounds, three stages of the cell
// coordinate divider (four, four and three quotient bits), and the glyph
// lookup with the color select, which is also the output register. A new pixel
// is taken in every cycle while in_stall is low.
// When the receiver stalls, the stages fill up behind the output register and
// in_stall rises once no stage is free; nothing is dropped or repeated.
// A write of shown_value starts a decimal conversion in the digit
// sequencer, during which in_stall stays high. Other writes act at once.
// Reset empties the pipeline, loads the register reset values and shows zero.
// ============================================================================
module digit_overlay_stamp_core #(
    parameter int DIGIT_COUNT = dos_pkg::DEFAULT_DIGIT_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [dos_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dos_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [dos_pkg::COORD_W-1:0]        pixel_x,
    input  logic [dos_pkg::COORD_W-1:0]        pixel_y,
    input  logic [dos_pkg::COLOR_W-1:0]        in_red,
    input  logic [dos_pkg::COLOR_W-1:0]        in_green,
    input  logic [dos_pkg::COLOR_W-1:0]        in_blue,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dos_pkg::COLOR_W-1:0]        out_red,
    output logic [dos_pkg::COLOR_W-1:0]        out_green,
    output logic [dos_pkg::COLOR_W-1:0]        out_blue
);

    localparam int DIV_STEPS_A = 4;
    localparam int DIV_STEPS_B = 4;
    localparam int DIV_STEPS_C = dos_pkg::COORD_W - DIV_STEPS_A - DIV_STEPS_B;

    logic                         enable_reg;
    logic [dos_pkg::COORD_W-1:0]  origin_x_reg;
    logic [dos_pkg::COORD_W-1:0]  origin_y_reg;
    logic [dos_pkg::SCALE_W-1:0]  scale_reg;

    logic                         conv_start;
    logic                         conv_busy;
    logic [DIGIT_COUNT-1:0][3:0]  digits;

    logic                         s1_valid_reg;
    dos_pkg::pix_beat_t           s1_beat_reg;
    dos_pkg::pix_beat_t           s1_beat_next;
    logic                         s1_ready;

    logic                         s2_valid;
    dos_pkg::pix_beat_t           s2_beat;
    logic                         s2_ready;
    logic                         s3_valid;
    dos_pkg::pix_beat_t           s3_beat;
    logic                         s3_ready;
    logic                         s4_valid;
    dos_pkg::pix_beat_t           s4_beat;
    logic                         s4_ready;

    logic                         out_valid_reg;
    logic [dos_pkg::COLOR_W-1:0]  red_reg;
    logic [dos_pkg::COLOR_W-1:0]  green_reg;
    logic [dos_pkg::COLOR_W-1:0]  blue_reg;
    logic [dos_pkg::COLOR_W-1:0]  red_next;
    logic [dos_pkg::COLOR_W-1:0]  green_next;
    logic [dos_pkg::COLOR_W-1:0]  blue_next;
    logic                         out_ready;

    logic                         in_accept;

    assign conv_start = cfg_write && (cfg_index == dos_pkg::REG_SHOWN_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= dos_pkg::RESET_OVERLAY_ENABLE;
            origin_x_reg <= dos_pkg::RESET_ORIGIN_X;
            origin_y_reg <= dos_pkg::RESET_ORIGIN_Y;
            scale_reg    <= dos_pkg::RESET_SCALE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dos_pkg::REG_OVERLAY_ENABLE: enable_reg   <= cfg_data[0];
                dos_pkg::REG_ORIGIN_X:       origin_x_reg <= cfg_data[dos_pkg::COORD_W-1:0];
                dos_pkg::REG_ORIGIN_Y:       origin_y_reg <= cfg_data[dos_pkg::COORD_W-1:0];
                dos_pkg::REG_SCALE:          scale_reg    <= cfg_data[dos_pkg::SCALE_W-1:0];
                default:                     ;
            endcase
        end
    end

    dos_bcd_conv #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_bcd_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .value  (cfg_data[dos_pkg::VALUE_W-1:0]),
        .busy   (conv_busy),
        .digits (digits)
    );

    assign in_stall  = conv_busy || !s1_ready;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        logic in_frame;
        logic past_origin;
        in_frame    = ({21'd0, pixel_x} < 32'(dos_pkg::FRAME_WIDTH))
                   && ({21'd0, pixel_y} < 32'(dos_pkg::FRAME_HEIGHT));
        past_origin = (pixel_x >= origin_x_reg) && (pixel_y >= origin_y_reg);
        s1_beat_next.active     = enable_reg && (scale_reg != '0) && in_frame && past_origin;
        s1_beat_next.lane_x.num = pixel_x - origin_x_reg;
        s1_beat_next.lane_x.quo = '0;
        s1_beat_next.lane_x.rem = '0;
        s1_beat_next.lane_y.num = pixel_y - origin_y_reg;
        s1_beat_next.lane_y.quo = '0;
        s1_beat_next.lane_y.rem = '0;
        s1_beat_next.red        = in_red;
        s1_beat_next.green      = in_green;
        s1_beat_next.blue       = in_blue;
    end

    assign s1_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_accept)
        begin
            s1_beat_reg <= s1_beat_next;
        end
    end

    dos_div_stage #(
        .STEPS (DIV_STEPS_A)
    ) u_div_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor    (scale_reg),
        .up_valid   (s1_valid_reg),
        .up_beat    (s1_beat_reg),
        .up_ready   (s2_ready),
        .down_valid (s2_valid),
        .down_beat  (s2_beat),
        .down_ready (s3_ready)
    );

    dos_div_stage #(
        .STEPS (DIV_STEPS_B)
    ) u_div_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor    (scale_reg),
        .up_valid   (s2_valid),
        .up_beat    (s2_beat),
        .up_ready   (s3_ready),
        .down_valid (s3_valid),
        .down_beat  (s3_beat),
        .down_ready (s4_ready)
    );

    dos_div_stage #(
        .STEPS (DIV_STEPS_C)
    ) u_div_c (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor    (scale_reg),
        .up_valid   (s3_valid),
        .up_beat    (s3_beat),
        .up_ready   (s4_ready),
        .down_valid (s4_valid),
        .down_beat  (s4_beat),
        .down_ready (out_ready)
    );

    always_comb
    begin
        logic [dos_pkg::COORD_W-1:0] cell_x;
        logic [dos_pkg::COORD_W-1:0] cell_y;
        logic                        in_box;
        logic [2:0]                  digit_idx;
        logic [1:0]                  col;
        logic [3:0]                  bit_pos;
        logic [3:0]                  digit_val;
        logic [dos_pkg::GLYPH_W-1:0] glyph_shifted;
        logic                        lit;
        cell_x    = s4_beat.lane_x.quo;
        cell_y    = s4_beat.lane_y.quo;
        in_box    = s4_beat.active
                 && (cell_x < dos_pkg::COORD_W'(4 * DIGIT_COUNT))
                 && (cell_y < dos_pkg::COORD_W'(dos_pkg::ROW_COUNT));
        digit_idx = cell_x[4:2];
        col       = cell_x[1:0];
        digit_val = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (digit_idx == 3'(DIGIT_COUNT - 1 - i))
            begin
                digit_val = digits[i];
            end
        end
        bit_pos       = 4'({1'b0, cell_y[2:0]} * 4'd3) + {2'b00, col};
        glyph_shifted = dos_pkg::GLYPH_W'(dos_pkg::glyph_bits(digit_val) << bit_pos);
        lit           = (col != dos_pkg::GAP_COL) && glyph_shifted[dos_pkg::GLYPH_W-1];
        priority if (!in_box)
        begin
            red_next   = s4_beat.red;
            green_next = s4_beat.green;
            blue_next  = s4_beat.blue;
        end
        else if (lit)
        begin
            red_next   = dos_pkg::WHITE_LEVEL;
            green_next = dos_pkg::WHITE_LEVEL;
            blue_next  = dos_pkg::WHITE_LEVEL;
        end
        else
        begin
            red_next   = dos_pkg::BLACK_LEVEL;
            green_next = dos_pkg::BLACK_LEVEL;
            blue_next  = dos_pkg::BLACK_LEVEL;
        end
    end

    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s4_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

>>> sim/tb_top.sv
// ============================================================================
// tb_top: testbench for the digit overlay stamp core
// Streams pixels through the overlay in bursts while the output side stalls
// on a changing pattern. Each accepted beat is run through a local model of
// the number box and the 3x5 font. Every output beat is compared, channel by
// channel, with the oldest prediction. The register settings change between
// phases: reset values, zero and oversized scale, disabled overlay, values
// past seven digits, origins at both ends of the coordinate range, and
// writes to unused register indexes.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_PIXELS  = 100;
    localparam int DRAIN_CYCLES  = 12;
    localparam int DIGITS        = dos_pkg::DEFAULT_DIGIT_COUNT;

    localparam logic [dos_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [dos_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [10*dos_pkg::GLYPH_W-1:0] FONT_ROM = {
        15'o35311, 15'o75757, 15'o71122, 15'o34652, 15'o74616,
        15'o13571, 15'o71717, 15'o25127, 15'o26227, 15'o75557
    };

    typedef struct packed
    {
        logic [dos_pkg::COORD_W-1:0] x;
        logic [dos_pkg::COORD_W-1:0] y;
        logic [dos_pkg::COLOR_W-1:0] red;
        logic [dos_pkg::COLOR_W-1:0] green;
        logic [dos_pkg::COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed
    {
        logic [dos_pkg::COLOR_W-1:0] red;
        logic [dos_pkg::COLOR_W-1:0] green;
        logic [dos_pkg::COLOR_W-1:0] blue;
    } color_t;

    typedef enum logic [1:0]
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [dos_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dos_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [dos_pkg::COORD_W-1:0]     pixel_x   = '0;
    logic [dos_pkg::COORD_W-1:0]     pixel_y   = '0;
    logic [dos_pkg::COLOR_W-1:0]     in_red    = '0;
    logic [dos_pkg::COLOR_W-1:0]     in_green  = '0;
    logic [dos_pkg::COLOR_W-1:0]     in_blue   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [dos_pkg::COLOR_W-1:0]     out_red;
    logic [dos_pkg::COLOR_W-1:0]     out_green;
    logic [dos_pkg::COLOR_W-1:0]     out_blue;

    logic                        ovl_enable   = dos_pkg::RESET_OVERLAY_ENABLE;
    logic [dos_pkg::COORD_W-1:0] box_x        = dos_pkg::RESET_ORIGIN_X;
    logic [dos_pkg::COORD_W-1:0] box_y        = dos_pkg::RESET_ORIGIN_Y;
    logic [dos_pkg::SCALE_W-1:0] cell_size    = dos_pkg::RESET_SCALE;
    logic [dos_pkg::VALUE_W-1:0] number_value = '0;

    pixel_t      pixel_queue[$];
    color_t      color_queue[$];
    pixel_t      cur_pixel;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int unsigned stall_run   = 0;
    int unsigned cycle_count = 0;
    int unsigned beats_in    = 0;
    int unsigned beats_out   = 0;
    int unsigned settings    = 1;
    int unsigned errors      = 0;

    digit_overlay_stamp_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic color_t stamp_color(pixel_t p);
        color_t                      c;
        int unsigned                 s;
        int unsigned                 cw;
        int unsigned                 dx;
        int unsigned                 dy;
        int unsigned                 col;
        int unsigned                 row;
        int unsigned                 place;
        int unsigned                 number;
        int unsigned                 dval;
        logic [dos_pkg::GLYPH_W-1:0] glyph;
        c.red   = p.red;
        c.green = p.green;
        c.blue  = p.blue;
        s       = cell_size;
        if (ovl_enable && s != 0
            && p.x < dos_pkg::FRAME_WIDTH && p.y < dos_pkg::FRAME_HEIGHT
            && p.x >= box_x && p.y >= box_y)
        begin
            dx = p.x - box_x;
            dy = p.y - box_y;
            cw = 4 * s;
            if (dx < cw * DIGITS && dy < 5 * s)
            begin
                c.red   = dos_pkg::BLACK_LEVEL;
                c.green = dos_pkg::BLACK_LEVEL;
                c.blue  = dos_pkg::BLACK_LEVEL;
                col     = (dx % cw) / s;
                row     = dy / s;
                if (col < 3)
                begin
                    place  = DIGITS - 1 - dx / cw;
                    number = number_value;
                    repeat (place) number = number / 10;
                    dval  = number % 10;
                    glyph = FONT_ROM[dval*dos_pkg::GLYPH_W +: dos_pkg::GLYPH_W];
                    if (glyph[dos_pkg::GLYPH_W-1-(row*3+col)])
                    begin
                        c.red   = dos_pkg::WHITE_LEVEL;
                        c.green = dos_pkg::WHITE_LEVEL;
                        c.blue  = dos_pkg::WHITE_LEVEL;
                    end
                end
            end
        end
        return c;
    endfunction

    function automatic logic [dos_pkg::CFG_DATA_W-1:0] with_noise(int unsigned field,
                                                                  int width);
        logic [dos_pkg::CFG_DATA_W-1:0] keep;
        keep = (dos_pkg::CFG_DATA_W'(1) << width) - dos_pkg::CFG_DATA_W'(1);
        return (dos_pkg::CFG_DATA_W'($urandom) & ~keep)
             | (dos_pkg::CFG_DATA_W'(field) & keep);
    endfunction

    function automatic logic [dos_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return '1;
            2:       return dos_pkg::WHITE_LEVEL;
            default: return dos_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [dos_pkg::COORD_W-1:0] near_box(
        logic [dos_pkg::COORD_W-1:0] origin, int unsigned span);
        int unsigned off;
        off = $urandom_range(span + 7, 0);
        return dos_pkg::COORD_W'(origin + off - 4);
    endfunction

    task automatic write_reg(input logic [dos_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dos_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            dos_pkg::REG_OVERLAY_ENABLE: ovl_enable   = data[0];
            dos_pkg::REG_ORIGIN_X:       box_x        = data[dos_pkg::COORD_W-1:0];
            dos_pkg::REG_ORIGIN_Y:       box_y        = data[dos_pkg::COORD_W-1:0];
            dos_pkg::REG_SCALE:          cell_size    = data[dos_pkg::SCALE_W-1:0];
            dos_pkg::REG_SHOWN_VALUE:    number_value = data[dos_pkg::VALUE_W-1:0];
            default:                     ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic queue_pixel(input int unsigned x, input int unsigned y,
                               input logic [dos_pkg::COLOR_W-1:0] r,
                               input logic [dos_pkg::COLOR_W-1:0] g,
                               input logic [dos_pkg::COLOR_W-1:0] b);
        pixel_t p;
        p.x     = dos_pkg::COORD_W'(x);
        p.y     = dos_pkg::COORD_W'(y);
        p.red   = r;
        p.green = g;
        p.blue  = b;
        pixel_queue.push_back(p);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || color_queue.size() != 0);
    endtask

    task automatic check_channel(input string name,
                                 input logic [dos_pkg::COLOR_W-1:0] want,
                                 input logic [dos_pkg::COLOR_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                color_queue.push_back(stamp_color(cur_pixel));
                beats_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    cur_pixel = pixel_queue.pop_front();
                    pixel_x  <= cur_pixel.x;
                    pixel_y  <= cur_pixel.y;
                    in_red   <= cur_pixel.red;
                    in_green <= cur_pixel.green;
                    in_blue  <= cur_pixel.blue;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(40, 0);
                        gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode = STALL_NONE;
            stall_run  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out++;
                if (color_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: output beat with nothing pending, expected none, actual %h %h %h",
                             $time, out_red, out_green, out_blue);
                end
                else
                begin
                    color_t want;
                    want = color_queue.pop_front();
                    check_channel("out_red", want.red, out_red);
                    check_channel("out_green", want.green, out_green);
                    check_channel("out_blue", want.blue, out_blue);
                end
            end
            if (stall_run == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(3, 0));
                stall_run  = $urandom_range(200, 20);
            end
            else
            begin
                stall_run--;
            end
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(3, 0) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(3, 0) != 0);
                STALL_TOGGLE: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d beats still pending",
                     cycle_count, color_queue.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned en;
        int unsigned sc;
        int unsigned ox;
        int unsigned oy;
        int unsigned val;
        int unsigned span_x;
        int unsigned span_y;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the first glyph, the gap, the box edges, the frame corners.
        queue_pixel(10, 30, '1, '1, '1);
        queue_pixel(14, 34, 16'h1234, 16'h5678, 16'h9abc);
        queue_pixel(22, 30, '1, '0, '1);
        queue_pixel(121, 49, 16'h00ff, 16'hff00, 16'h0f0f);
        queue_pixel(122, 30, 16'hfedc, 16'hba98, 16'h7654);
        queue_pixel(10, 50, 16'h3210, 16'hcdef, 16'h89ab);
        queue_pixel(9, 30, 16'h5555, 16'haaaa, 16'h0001);
        queue_pixel(0, 0, '0, '0, '0);
        queue_pixel(2047, 2047, '1, '1, '1);
        queue_pixel(2047, 0, 16'h8000, 16'h0001, 16'h7fff);
        queue_pixel(0, 2047, 16'h0001, 16'h8000, 16'hfffe);
        wait_drained();

        write_reg(REG_SPARE_FIRST, dos_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_LAST, dos_pkg::CFG_DATA_W'($urandom));
        queue_pixel(10, 30, 16'h1111, 16'h2222, 16'h3333);
        wait_drained();

        write_reg(dos_pkg::REG_OVERLAY_ENABLE, 24'd0);
        queue_pixel(10, 30, 16'h4444, 16'h5555, 16'h6666);
        wait_drained();

        write_reg(dos_pkg::REG_OVERLAY_ENABLE, 24'd1);
        write_reg(dos_pkg::REG_SCALE, 24'd0);
        queue_pixel(10, 30, 16'h7777, 16'h8888, 16'h9999);
        queue_pixel(11, 31, 16'haaaa, 16'hbbbb, 16'hcccc);
        wait_drained();

        // Scale one at the origin, with a value past seven digits.
        write_reg(dos_pkg::REG_SCALE, 24'd1);
        write_reg(dos_pkg::REG_ORIGIN_X, 24'd0);
        write_reg(dos_pkg::REG_ORIGIN_Y, 24'd0);
        write_reg(dos_pkg::REG_SHOWN_VALUE, 24'hffffff);
        queue_pixel(0, 0, 16'hdddd, 16'heeee, 16'hffff);
        queue_pixel(4, 0, 16'h0102, 16'h0304, 16'h0506);
        queue_pixel(27, 4, 16'h0708, 16'h090a, 16'h0b0c);
        queue_pixel(28, 0, 16'h0d0e, 16'h0f10, 16'h1112);
        queue_pixel(0, 5, 16'h1314, 16'h1516, 16'h1718);
        queue_pixel(26, 4, 16'h191a, 16'h1b1c, 16'h1d1e);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            en  = ($urandom_range(9, 0) != 0);
            sc  = ($urandom_range(3, 0) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
            ox  = $urandom_range(2047, 0);
            oy  = $urandom_range(2047, 0);
            val = ($urandom_range(4, 0) == 0) ? ($urandom & 32'hffffff)
                                              : $urandom_range(9999999, 0);
            case (ph)
                0:
                begin
                    en = 1;
                    sc = 1;
                    ox = 0;
                    oy = 0;
                end
                1:
                begin
                    en = 1;
                    sc = 31;
                end
                2:
                begin
                    en  = 1;
                    sc  = 16;
                    val = 9999999;
                end
                3:
                begin
                    en  = 1;
                    val = 32'hffffff;
                end
                4:       en = 0;
                5:
                begin
                    en = 1;
                    sc = 2;
                    ox = 2047;
                    oy = 2047;
                end
                6:       sc = 0;
                default: ;
            endcase
            write_reg(dos_pkg::REG_OVERLAY_ENABLE, with_noise(en, 1));
            write_reg(dos_pkg::REG_ORIGIN_X, with_noise(ox, dos_pkg::COORD_W));
            write_reg(dos_pkg::REG_ORIGIN_Y, with_noise(oy, dos_pkg::COORD_W));
            write_reg(dos_pkg::REG_SCALE, with_noise(sc, dos_pkg::SCALE_W));
            if ($urandom_range(3, 0) == 0)
            begin
                write_reg(dos_pkg::CFG_INDEX_W'($urandom_range(REG_SPARE_LAST,
                                                               REG_SPARE_FIRST)),
                          dos_pkg::CFG_DATA_W'($urandom));
            end
            write_reg(dos_pkg::REG_SHOWN_VALUE, dos_pkg::CFG_DATA_W'(val));

            span_x = (cell_size == 0) ? 16 : 4 * DIGITS * cell_size;
            span_y = (cell_size == 0) ? 16 : 5 * cell_size;
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if ($urandom_range(4, 0) != 0)
                begin
                    queue_pixel(near_box(box_x, span_x), near_box(box_y, span_y),
                                pick_color(), pick_color(), pick_color());
                end
                else
                begin
                    queue_pixel($urandom_range(2047, 0), $urandom_range(2047, 0),
                                pick_color(), pick_color(), pick_color());
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Streamed %0d pixels under %0d register writes and checked %0d output beats.",
                 beats_in, settings - 1, beats_out);
        $display("Mismatches: %0d, predictions left over: %0d", errors, color_queue.size());
        if (errors == 0 && color_queue.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
